// ----- rtl/core/http_host_packet_filter_assert.svh -----
// Assertion macros for the packet filter RTL.
`ifndef HTTP_HOST_PACKET_FILTER_ASSERT_SVH
`define HTTP_HOST_PACKET_FILTER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define HHPF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("packet filter assertion failed");

// Consequent checked in the cycle after the antecedent.
`define HHPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("packet filter assertion failed");

`endif

// ----- rtl/core/hhpf_pkg.sv -----
// Shared types and constants of the HTTP host packet filter.
`default_nettype none
package hhpf_pkg;

   localparam int PATTERN_MAX = 32;
   localparam int PAT_IDX_W   = $clog2(PATTERN_MAX);
   localparam int LEN_W       = 6;
   localparam int POS_W       = 16;
   localparam int HDR_W       = 6;
   localparam int START_W     = 7;
   localparam int PORT_W      = 16;
   localparam int ID_W        = 32;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 3;

   // byte offsets relative to the start of the TCP header
   localparam logic [POS_W-1:0]   PORT_HI_OFS    = 16'd2;
   localparam logic [POS_W-1:0]   PORT_LO_OFS    = 16'd3;
   localparam logic [POS_W-1:0]   DATA_OFS_OFS   = 16'd12;
   localparam logic [START_W-1:0] PAYLOAD_MIN_OFS = 7'd13;
   localparam logic [POS_W-1:0]   POS_MAX        = 16'hffff;

   localparam logic [PORT_W-1:0]  MATCH_PORT_RST  = 16'd80;
   localparam logic [LEN_W-1:0]   PAT_LEN_RST     = 6'd1;

   typedef logic [PATTERN_MAX-1:0][7:0] pat_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MATCH_PORT     = 3'd0,
      CSR_PATTERN_LENGTH = 3'd1,
      CSR_PATTERN_WORD_A = 3'd2,
      CSR_PATTERN_WORD_B = 3'd3,
      CSR_PATTERN_WORD_C = 3'd4,
      CSR_PATTERN_WORD_D = 3'd5
   } csr_idx_type;

   // per-beat control from the header parser to the payload matcher
   typedef struct packed {
      logic beat;   // input beat accepted
      logic last;   // beat closes the packet
      logic take;   // beat is a payload byte
   } beat_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/core/hhpf_parse.sv -----
// Header parser: byte position, IP/TCP header lengths and port compare.
`default_nettype none
module hhpf_parse
   import hhpf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              beat,
   input  wire logic              last,
   input  wire logic [7:0]        data,
   input  wire logic [PORT_W-1:0] match_port,
   output beat_ctl_type           ctl,
   output logic                   port_hit
);

   logic [POS_W-1:0] pos_ff,   pos_in;
   logic [HDR_W-1:0] ip_ff,    ip_in;
   logic [HDR_W-1:0] tcp_ff,   tcp_in;
   logic [7:0]       phigh_ff, phigh_in;
   logic             pmatch_ff, pmatch_in;

   logic [HDR_W-1:0]   ip_cur;
   logic [HDR_W-1:0]   tcp_cur;
   logic [POS_W-1:0]   ip_ext;
   logic [START_W-1:0] tcp_min;
   logic [START_W-1:0] start;

   always_comb begin
      ip_cur  = (pos_ff == '0) ? {data[3:0], 2'b00} : ip_ff;
      ip_ext  = POS_W'(ip_cur);
      tcp_cur = (pos_ff == ip_ext + DATA_OFS_OFS) ? {data[7:4], 2'b00} : tcp_ff;
      port_hit = (pos_ff == ip_ext + PORT_LO_OFS) ? ({phigh_ff, data} == match_port)
                                                  : pmatch_ff;
      tcp_min = (START_W'(tcp_cur) < PAYLOAD_MIN_OFS) ? PAYLOAD_MIN_OFS
                                                       : START_W'(tcp_cur);
      start   = START_W'(ip_cur) + tcp_min;
      ctl.beat = beat;
      ctl.last = last;
      ctl.take = beat && (pos_ff >= POS_W'(start));
   end

   always_comb begin
      pos_in    = pos_ff;
      ip_in     = ip_ff;
      tcp_in    = tcp_ff;
      phigh_in  = phigh_ff;
      pmatch_in = pmatch_ff;
      if (beat) begin
         if (last) begin
            pos_in    = '0;
            ip_in     = '0;
            tcp_in    = '0;
            phigh_in  = '0;
            pmatch_in = 1'b0;
         end else begin
            pos_in    = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
            ip_in     = ip_cur;
            tcp_in    = tcp_cur;
            pmatch_in = port_hit;
            if (pos_ff == ip_ext + PORT_HI_OFS) begin
               phigh_in = data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         ip_ff     <= '0;
         tcp_ff    <= '0;
         phigh_ff  <= '0;
         pmatch_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         ip_ff     <= ip_in;
         tcp_ff    <= tcp_in;
         phigh_ff  <= phigh_in;
         pmatch_ff <= pmatch_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/hhpf_match.sv -----
// Payload matcher: shift window of recent payload bytes and parallel compare.
`default_nettype none
module hhpf_match
   import hhpf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire beat_ctl_type     ctl,
   input  wire logic [7:0]       data,
   input  wire pat_type          pattern,
   input  wire logic [LEN_W-1:0] pattern_length,
   output logic                  found
);

   pat_type          win_ff,   win_in;
   logic [LEN_W-1:0] held_ff,  held_in;
   logic             found_ff, found_in;

   pat_type                win_new;
   logic [LEN_W-1:0]       held_new;
   logic [LEN_W-1:0]       len_eff;
   logic [PATTERN_MAX-1:0] eq;
   logic [LEN_W-1:0]       idx;
   logic                   hit;

   always_comb begin
      if (pattern_length == '0) begin
         len_eff = LEN_W'(1);
      end else if (pattern_length > LEN_W'(PATTERN_MAX)) begin
         len_eff = LEN_W'(PATTERN_MAX);
      end else begin
         len_eff = pattern_length;
      end

      // newest byte lands in slot 0
      win_new  = ctl.take ? {win_ff[PATTERN_MAX-2:0], data} : win_ff;
      held_new = held_ff;
      if (ctl.take && (held_ff < LEN_W'(PATTERN_MAX))) begin
         held_new = held_ff + 1'b1;
      end

      // slot k holds the byte that pairs with pattern byte len-1-k
      idx = '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         idx   = len_eff - LEN_W'(k) - 1'b1;
         eq[k] = (LEN_W'(k) >= len_eff) || (win_new[k] == pattern[idx[PAT_IDX_W-1:0]]);
      end

      hit   = ctl.take && (held_new >= len_eff) && (&eq);
      found = found_ff || hit;
   end

   always_comb begin
      win_in   = win_ff;
      held_in  = held_ff;
      found_in = found_ff;
      if (ctl.beat) begin
         if (ctl.last) begin
            win_in   = '0;
            held_in  = '0;
            found_in = 1'b0;
         end else begin
            win_in   = win_new;
            held_in  = held_new;
            found_in = found;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         held_ff  <= held_in;
         found_ff <= found_in;
      end
   end

   // window contents are gated by held_ff, no reset needed
   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule
`default_nettype wire

// ----- rtl/core/http_host_packet_filter.sv -----
// HTTP host packet filter top level: config registers, parser, matcher, verdict register.
//
// Takes an IPv4 packet one byte per beat, starting at the IP header, and gives one verdict
// beat on the packet's last byte: drop=1 when the TCP destination port equals match_port
// and the configured pattern (1 to 32 bytes) appears entirely inside the TCP payload,
// drop=0 otherwise (short packets are accepted). One byte is taken every cycle; the header
// parse, the window shift and the 32-byte parallel compare are all combinational between
// the per-packet state registers, and the verdict is registered and comes out in the cycle
// after the last byte. The input stalls only while a verdict is held and not taken.
// Registers are written through csr_* and must only change between packets.
`default_nettype none
`include "http_host_packet_filter_assert.svh"
module http_host_packet_filter
   import hhpf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // config write port
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   // packet byte stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [39:0]           req_tdata,   // packet_byte[7:0], queue_id[39:8]
   input  wire logic                  req_tlast,   // end_of_packet
   // verdict stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [39:0]                rsp_tdata    // drop[0], verdict_id[32:1], zero[39:33]
);

   logic [PORT_W-1:0]     port_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [CSR_DATA_W-1:0] word_a_ff, word_b_ff, word_c_ff, word_d_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   logic            drop_ff,      drop_in;
   logic [ID_W-1:0] id_ff,        id_in;

   logic         accept;
   beat_ctl_type ctl;
   logic         port_hit;
   logic         found;
   pat_type      pattern;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_ff   <= MATCH_PORT_RST;
         len_ff    <= PAT_LEN_RST;
         word_a_ff <= '0;
         word_b_ff <= '0;
         word_c_ff <= '0;
         word_d_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MATCH_PORT:     port_ff   <= csr_wdata[PORT_W-1:0];
            CSR_PATTERN_LENGTH: len_ff    <= csr_wdata[LEN_W-1:0];
            CSR_PATTERN_WORD_A: word_a_ff <= csr_wdata;
            CSR_PATTERN_WORD_B: word_b_ff <= csr_wdata;
            CSR_PATTERN_WORD_C: word_c_ff <= csr_wdata;
            CSR_PATTERN_WORD_D: word_d_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign pattern    = {word_d_ff, word_c_ff, word_b_ff, word_a_ff};
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   hhpf_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .beat       (accept),
      .last       (req_tlast),
      .data       (req_tdata[7:0]),
      .match_port (port_ff),
      .ctl        (ctl),
      .port_hit   (port_hit)
   );

   hhpf_match u_match (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .data           (req_tdata[7:0]),
      .pattern        (pattern),
      .pattern_length (len_ff),
      .found          (found)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      drop_in      = drop_ff;
      id_in        = id_ff;
      if (ctl.beat && ctl.last) begin
         rsp_valid_in = 1'b1;
         drop_in      = port_hit && found;
         id_in        = req_tdata[39:8];
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drop_ff <= drop_in;
      id_ff   <= id_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, id_ff, drop_ff};

   `HHPF_ASSERT_NEXT(a_last_gives_verdict, clock, reset, accept && req_tlast, rsp_tvalid)
   `HHPF_ASSERT_NEXT(a_no_verdict_midpacket, clock, reset, accept && !req_tlast && !rsp_tvalid, !rsp_tvalid)
   `HHPF_ASSERT_NOW(a_verdict_from_last, clock, reset, $rose(rsp_tvalid), $past(accept && req_tlast))

endmodule
`default_nettype wire
